// File: hw/rtl/bfd_pkg.sv
// Shared constants, types and helper functions of the box filter downsampler.
`timescale 1ns / 1ps

package bfd_pkg;

  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MAX_SCALE_DEF    = 8;
  localparam int CHANNEL_BITS_DEF = 16;

  localparam int PIX_W       = 16;
  localparam int DEPTH_W     = 32;
  localparam int COORD_W     = 11;
  localparam int CFG_DIM_W   = 12;
  localparam int CFG_SCALE_W = 4;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_DIM_W-1:0]   WIDTH_RST  = 12'd1024;
  localparam logic [CFG_DIM_W-1:0]   HEIGHT_RST = 12'd1024;
  localparam logic [CFG_SCALE_W-1:0] SCALE_RST  = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic cap;
    logic acc;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic inblock;
    logic last;
  } stat_t;

  // growth of a block sum over a single pixel
  function automatic int sum_ext(int max_scale);
    return 2 * $clog2(max_scale);
  endfunction

  // one quotient bit per step over the widest (depth) sum
  function automatic int div_steps(int max_scale);
    return DEPTH_W + sum_ext(max_scale);
  endfunction

endpackage

// File: hw/rtl/bfd_if.sv
// Request channels of the box filter downsampler: pixel in, result out, configuration.
`timescale 1ns / 1ps

interface bfd_pix_if;
  import bfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   red;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   blue;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, red, green, blue, depth, input ready);
  modport sink   (input valid, red, green, blue, depth, output ready);
endinterface

interface bfd_res_if;
  import bfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [PIX_W-1:0]   red_out;
  logic [PIX_W-1:0]   green_out;
  logic [PIX_W-1:0]   blue_out;
  logic [DEPTH_W-1:0] depth_out;
  logic               frame_last;

  modport source (output valid, out_x, out_y, red_out, green_out, blue_out, depth_out,
                  frame_last, input ready);
  modport sink   (input valid, out_x, out_y, red_out, green_out, blue_out, depth_out,
                  frame_last, output ready);
endinterface

interface bfd_cfg_if;
  import bfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bfd_div.sv
// Restoring divider lane, one quotient bit per step.
`timescale 1ns / 1ps

module bfd_div #(
  parameter int W     = 38,
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [W-1:0]     dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [W-1:0]     quot_o
);
  import bfd_pkg::*;

  logic [W-1:0]     q_q, q_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;

  always_comb begin
    trial = {rem_q, q_q[W-1]};
    q_d   = q_q;
    rem_d = rem_q;
    if (load_i) begin
      q_d   = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DVS_W'(trial - {1'b0, divisor_i});
        q_d   = {q_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        q_d   = {q_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
  end

  assign quot_o = q_q;

endmodule

// File: hw/rtl/bfd_dp.sv
// Datapath: configuration, raster counters, column accumulator memory, dividers, result register.
`timescale 1ns / 1ps

module bfd_dp #(
  parameter int MAX_WIDTH    = bfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE    = bfd_pkg::MAX_SCALE_DEF,
  parameter int CHANNEL_BITS = bfd_pkg::CHANNEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfd_pkg::cmd_t                   cmd_i,
  output bfd_pkg::stat_t                  stat_o,
  input  logic [bfd_pkg::PIX_W-1:0]       red_i,
  input  logic [bfd_pkg::PIX_W-1:0]       green_i,
  input  logic [bfd_pkg::PIX_W-1:0]       blue_i,
  input  logic [bfd_pkg::DEPTH_W-1:0]     depth_i,
  input  logic                            cfg_we_i,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [bfd_pkg::COORD_W-1:0]     out_x_o,
  output logic [bfd_pkg::COORD_W-1:0]     out_y_o,
  output logic [bfd_pkg::PIX_W-1:0]       red_out_o,
  output logic [bfd_pkg::PIX_W-1:0]       green_out_o,
  output logic [bfd_pkg::PIX_W-1:0]       blue_out_o,
  output logic [bfd_pkg::DEPTH_W-1:0]     depth_out_o,
  output logic                            frame_last_o
);
  import bfd_pkg::*;

  localparam int CB       = (CHANNEL_BITS < PIX_W) ? CHANNEL_BITS : PIX_W;
  localparam int SEXT     = sum_ext(MAX_SCALE);
  localparam int CSW      = CB + SEXT;
  localparam int DSW      = DEPTH_W + SEXT;
  localparam int MEM_W    = 3 * CSW + DSW;
  localparam int CNT_W    = $clog2(MAX_WIDTH);
  localparam int DIM_BITS = $clog2(MAX_WIDTH + 1);
  localparam int CW       = ((DIM_BITS > CFG_DIM_W) ? DIM_BITS : CFG_DIM_W) + 2;
  localparam int S_W      = $clog2(MAX_SCALE + 1);
  localparam int SCW      = (S_W > CFG_SCALE_W) ? S_W : CFG_SCALE_W;
  localparam int DVS_W    = $clog2(MAX_SCALE * MAX_SCALE + 1);

  // configuration
  logic [CFG_DIM_W-1:0]   width_q, height_q;
  logic [CFG_SCALE_W-1:0] scale_q;
  logic                   cfg_hit;

  always_comb begin
    cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_SRC_WIDTH) || (cfg_idx_i == CFG_SRC_HEIGHT) ||
                           (cfg_idx_i == CFG_SCALE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      scale_q  <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH:  width_q  <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_SRC_HEIGHT: height_q <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_SCALE:      scale_q  <= cfg_data_i[CFG_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CW-1:0]  w_c, h_c, s_c, w_ext, h_ext;
  logic [SCW-1:0] sc_ext, sc_cl;
  logic [S_W-1:0] s_n;

  always_comb begin
    w_ext  = CW'(width_q);
    h_ext  = CW'(height_q);
    sc_ext = SCW'(scale_q);
    if (width_q == '0)               w_c = CW'(1);
    else if (w_ext > CW'(MAX_WIDTH)) w_c = CW'(MAX_WIDTH);
    else                             w_c = w_ext;
    if (height_q == '0)              h_c = CW'(1);
    else if (h_ext > CW'(MAX_WIDTH)) h_c = CW'(MAX_WIDTH);
    else                             h_c = h_ext;
    if (scale_q == '0)                sc_cl = SCW'(1);
    else if (sc_ext > SCW'(MAX_SCALE)) sc_cl = SCW'(MAX_SCALE);
    else                              sc_cl = sc_ext;
    s_n = S_W'(sc_cl);
    s_c = CW'(sc_cl);
  end

  // raster position: source column/row, offset inside block, block index, block origin
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] bx_q, bx_d, by_q, by_d;
  logic [CNT_W-1:0] cbase_q, cbase_d, rbase_q, rbase_d;
  logic [S_W-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic             col_end, row_end, sx_end, sy_end;
  logic             in_col, in_row, first_c, last_c, fl_c;

  always_comb begin
    col_end = (CW'(col_q) + CW'(1)) >= w_c;
    row_end = (CW'(row_q) + CW'(1)) >= h_c;
    sx_end  = (sx_q + S_W'(1)) == s_n;
    sy_end  = (sy_q + S_W'(1)) == s_n;
    in_col  = (CW'(cbase_q) + s_c) <= w_c;
    in_row  = (CW'(rbase_q) + s_c) <= h_c;
    first_c = (sx_q == '0) && (sy_q == '0);
    last_c  = sx_end && sy_end;
    // no room for another whole block to the right and below
    fl_c    = ((CW'(cbase_q) + (s_c << 1)) > w_c) && ((CW'(rbase_q) + (s_c << 1)) > h_c);
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    bx_d    = bx_q;
    by_d    = by_q;
    cbase_d = cbase_q;
    rbase_d = rbase_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    if (cfg_hit) begin
      col_d   = '0;
      row_d   = '0;
      bx_d    = '0;
      by_d    = '0;
      cbase_d = '0;
      rbase_d = '0;
      sx_d    = '0;
      sy_d    = '0;
    end else if (cmd_i.cap) begin
      if (col_end) begin
        col_d   = '0;
        sx_d    = '0;
        bx_d    = '0;
        cbase_d = '0;
        if (row_end) begin
          row_d   = '0;
          sy_d    = '0;
          by_d    = '0;
          rbase_d = '0;
        end else begin
          row_d = row_q + CNT_W'(1);
          if (sy_end) begin
            sy_d    = '0;
            by_d    = by_q + CNT_W'(1);
            rbase_d = rbase_q + CNT_W'(s_c);
          end else begin
            sy_d = sy_q + S_W'(1);
          end
        end
      end else begin
        col_d = col_q + CNT_W'(1);
        if (sx_end) begin
          sx_d    = '0;
          bx_d    = bx_q + CNT_W'(1);
          cbase_d = cbase_q + CNT_W'(s_c);
        end else begin
          sx_d = sx_q + S_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      cbase_q <= '0;
      rbase_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      bx_q    <= bx_d;
      by_q    <= by_d;
      cbase_q <= cbase_d;
      rbase_q <= rbase_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
    end
  end

  // captured request
  logic [CB-1:0]      px_r_q, px_g_q, px_b_q;
  logic [DEPTH_W-1:0] px_d_q;
  logic [CNT_W-1:0]   addr_q, by_lat_q;
  logic               first_q, last_q, fl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      px_r_q   <= CB'(red_i);
      px_g_q   <= CB'(green_i);
      px_b_q   <= CB'(blue_i);
      px_d_q   <= depth_i;
      addr_q   <= bx_q;
      by_lat_q <= by_q;
      first_q  <= first_c;
      last_q   <= last_c;
      fl_q     <= fl_c;
    end
  end

  assign stat_o = '{inblock: in_col && in_row, last: last_q};

  // per-block-column accumulators {red, green, blue, depth}; first pixel of a block overwrites
  logic [MEM_W-1:0] acc_mem [MAX_WIDTH];
  logic [MEM_W-1:0] rd_q, wr_d;
  logic [CSW-1:0]   sum_r, sum_g, sum_b;
  logic [DSW-1:0]   sum_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      rd_q <= acc_mem[bx_q];
    end
    if (cmd_i.acc) begin
      acc_mem[addr_q] <= wr_d;
    end
  end

  always_comb begin
    if (first_q) begin
      sum_r = CSW'(px_r_q);
      sum_g = CSW'(px_g_q);
      sum_b = CSW'(px_b_q);
      sum_d = DSW'(px_d_q);
    end else begin
      sum_r = rd_q[MEM_W-1 -: CSW] + CSW'(px_r_q);
      sum_g = rd_q[MEM_W-CSW-1 -: CSW] + CSW'(px_g_q);
      sum_b = rd_q[DSW+CSW-1 -: CSW] + CSW'(px_b_q);
      sum_d = rd_q[DSW-1:0] + DSW'(px_d_q);
    end
    wr_d = {sum_r, sum_g, sum_b, sum_d};
  end

  // divide by scale squared
  logic [DVS_W-1:0] divisor_q;
  logic [DSW-1:0]   q_r, q_g, q_b, q_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      divisor_q <= DVS_W'(s_n) * DVS_W'(s_n);
    end
  end

  bfd_div #(.W(DSW), .DVS_W(DVS_W)) u_div_r (
    .clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
    .dividend_i(DSW'(sum_r)), .divisor_i(divisor_q), .quot_o(q_r)
  );
  bfd_div #(.W(DSW), .DVS_W(DVS_W)) u_div_g (
    .clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
    .dividend_i(DSW'(sum_g)), .divisor_i(divisor_q), .quot_o(q_g)
  );
  bfd_div #(.W(DSW), .DVS_W(DVS_W)) u_div_b (
    .clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
    .dividend_i(DSW'(sum_b)), .divisor_i(divisor_q), .quot_o(q_b)
  );
  bfd_div #(.W(DSW), .DVS_W(DVS_W)) u_div_d (
    .clk_i, .load_i(cmd_i.div_load), .step_i(cmd_i.div_step),
    .dividend_i(sum_d), .divisor_i(divisor_q), .quot_o(q_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_o      <= COORD_W'(addr_q);
      out_y_o      <= COORD_W'(by_lat_q);
      red_out_o    <= PIX_W'(q_r);
      green_out_o  <= PIX_W'(q_g);
      blue_out_o   <= PIX_W'(q_b);
      depth_out_o  <= DEPTH_W'(q_d);
      frame_last_o <= fl_q;
    end
  end

endmodule

// File: hw/rtl/bfd_ctrl.sv
// Controller: sequences capture, accumulate, divide and result handoff.
`timescale 1ns / 1ps

module bfd_ctrl #(
  parameter int MAX_SCALE = bfd_pkg::MAX_SCALE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pix_valid_i,
  output logic           pix_ready_o,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  output logic           cfg_ready_o,
  input  bfd_pkg::stat_t stat_i,
  output bfd_pkg::cmd_t  cmd_o
);
  import bfd_pkg::*;

  localparam int DIV_N = div_steps(MAX_SCALE);
  localparam int CNT_W = $clog2(DIV_N + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             res_valid_q, res_valid_d;
  logic             out_free, div_done;

  assign out_free    = !res_valid_q || res_ready_i;
  assign div_done    = (cnt_q == CNT_W'(DIV_N));
  assign res_valid_o = res_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pix_valid_i && stat_i.inblock) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = stat_i.last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    cnt_d       = cnt_q;
    case (state_q)
      ST_IDLE: begin
        pix_ready_o = 1'b1;
        cmd_o.cap   = pix_valid_i;
      end
      ST_ACC: begin
        cmd_o.acc      = 1'b1;
        cmd_o.div_load = stat_i.last;
        cnt_d          = '0;
      end
      ST_DIV: begin
        if (!div_done) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + CNT_W'(1);
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
        end
      end
      default: ;
    endcase
    res_valid_d = cmd_o.out_load ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  a_acc_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> (state_q == ST_IDLE || state_q == ST_DIV))
    else $error("accumulate step did not finish in one cycle");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !div_done) |=> state_q == ST_DIV)
    else $error("divide left before all quotient bits");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_DIV))
    else $error("result raised outside divide");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= CNT_W'(DIV_N))
    else $error("divide step count overrun");

endmodule

// File: hw/rtl/box_filter_downsampler_unit.sv
// Box filter downsampler: averages scale x scale source blocks into one result pixel.
// Pixel outside a whole block: accepted in the IDLE state alone. Pixel inside a block:
// capture in IDLE, then read-modify-write of the column accumulator memory in ACC.
// Block-final pixel: after ACC the bit-serial divider takes one quotient bit per cycle
// over 38 bits (default widths); result valid when the output is free, then back to accept.
// Reset: size 1024x1024, scale 2, counters zero; accumulators are not cleared.
`timescale 1ns / 1ps

module box_filter_downsampler_unit #(
  parameter int MAX_WIDTH    = bfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE    = bfd_pkg::MAX_SCALE_DEF,
  parameter int CHANNEL_BITS = bfd_pkg::CHANNEL_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfd_pix_if.sink   pix_i,
  bfd_res_if.source res_o,
  bfd_cfg_if.sink   cfg_i
);
  import bfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfd_ctrl #(.MAX_SCALE(MAX_SCALE)) u_ctrl (
    .clk_i,
    .rst_ni,
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .cfg_ready_o (cfg_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfd_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_SCALE    (MAX_SCALE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .red_i        (pix_i.red),
    .green_i      (pix_i.green),
    .blue_i       (pix_i.blue),
    .depth_i      (pix_i.depth),
    .cfg_we_i     (cfg_i.valid && cfg_i.ready),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_x_o      (res_o.out_x),
    .out_y_o      (res_o.out_y),
    .red_out_o    (res_o.red_out),
    .green_out_o  (res_o.green_out),
    .blue_out_o   (res_o.blue_out),
    .depth_out_o  (res_o.depth_out),
    .frame_last_o (res_o.frame_last)
  );

endmodule
